FILE: sv/ttgt_pkg.sv
// Shared constants and codes of the touchpad tap and glide translator.
// No dependencies; imported by the top level, ttgt_front, ttgt_back and the bench.
package ttgt_pkg;

    // Default coordinate width; coordinates saturate at 2^COORD_BITS-1
    localparam int COORD_BITS_DEF = 9;

    // Scaled quotient width: (v+32767)*255/(top+32767) never exceeds 510
    localparam int QUOT_BITS = 9;
    localparam int PROD_BITS = 24;
    localparam int DIVR_BITS = 16;
    localparam int RAW_BITS  = 16;
    localparam int TIME_BITS = 32;
    localparam int TOP_BITS  = 15;
    localparam int LIM_BITS  = 8;
    localparam int DELTA_BITS = 6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Input command codes
    localparam logic [1:0] CMD_X_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_Y_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_FINGER_UP = 2'd2;
    localparam logic [1:0] CMD_OTHER     = 2'd3;

    // Result action codes
    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_LEFT  = 2'd1;
    localparam logic [1:0] ACT_RIGHT = 2'd2;

    // Register map indexes
    localparam logic [1:0] REG_X_TOP       = 2'd0;
    localparam logic [1:0] REG_Y_TOP       = 2'd1;
    localparam logic [1:0] REG_JUMP_LIMIT  = 2'd2;
    localparam logic [1:0] REG_GLIDE_START = 2'd3;

    // Register reset values
    localparam logic [TOP_BITS-1:0] X_TOP_RST       = 15'd5800;
    localparam logic [TOP_BITS-1:0] Y_TOP_RST       = 15'd16000;
    localparam logic [LIM_BITS-1:0] JUMP_LIMIT_RST  = 8'd10;
    localparam logic [LIM_BITS-1:0] GLIDE_START_RST = 8'd10;

    // Offset that moves a signed raw reading onto a 0-based scale
    localparam logic [DIVR_BITS-1:0] RAW_OFFSET = 16'd32767;

endpackage

FILE: sv/touchpad_tap_and_glide_translator.sv
// Touchpad tap and glide translator: X/Y samples and finger-up words in, moves and clicks out.
// The front takes no new word until it has pushed the last; X/Y samples first pass through
//   the 9-step serial divider in the front. The back takes no new word until it has judged the
//   last one and, when a finger-up gives a click and a move, loaded the move behind the click.
// Reset: aresetn synchronous, active low; clears gesture state, reloads register defaults.
// Depends on ttgt_pkg, ttgt_front, ttgt_queue, ttgt_back.
module touchpad_tap_and_glide_translator #(
    parameter int COORD_BITS  = ttgt_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = ttgt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_value [15:0], now_seconds [47:16]
    input  logic [1:0]  s_tuser,   // command [1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // move_dx [5:0], move_dy [11:6], zero [15:12]
    output logic [1:0]  m_tuser,   // action [1:0]
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ttgt_pkg::*;

    localparam int QW = 2 + COORD_BITS + TIME_BITS;

    logic [TOP_BITS-1:0] x_top_reg, y_top_reg;
    logic [LIM_BITS-1:0] jump_limit_reg, glide_start_reg;
    logic                cfg_write;
    logic [1:0]          cfg_index;

    logic                  f_push_valid, f_push_ready;
    logic [1:0]            f_cmd;
    logic [COORD_BITS-1:0] f_coord;
    logic [TIME_BITS-1:0]  f_now;
    logic                  b_pop_valid, b_pop_ready;
    logic [QW-1:0]         q_in, q_out;
    logic [DELTA_BITS-1:0] out_dx, out_dy;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_top_reg       <= X_TOP_RST;
            y_top_reg       <= Y_TOP_RST;
            jump_limit_reg  <= JUMP_LIMIT_RST;
            glide_start_reg <= GLIDE_START_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_X_TOP:       x_top_reg       <= pwdata[TOP_BITS-1:0];
                REG_Y_TOP:       y_top_reg       <= pwdata[TOP_BITS-1:0];
                REG_JUMP_LIMIT:  jump_limit_reg  <= pwdata[LIM_BITS-1:0];
                REG_GLIDE_START: glide_start_reg <= pwdata[LIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_X_TOP:       prdata = 32'(x_top_reg);
            REG_Y_TOP:       prdata = 32'(y_top_reg);
            REG_JUMP_LIMIT:  prdata = 32'(jump_limit_reg);
            REG_GLIDE_START: prdata = 32'(glide_start_reg);
            default:         prdata = '0;
        endcase
    end

    // front: accept and scale
    ttgt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_command       (s_tuser),
        .in_raw_value     (s_tdata[15:0]),
        .in_now_seconds   (s_tdata[47:16]),
        .x_axis_top       (x_top_reg),
        .y_axis_top       (y_top_reg),
        .push_valid       (f_push_valid),
        .push_ready       (f_push_ready),
        .push_command     (f_cmd),
        .push_coord       (f_coord),
        .push_now_seconds (f_now)
    );

    assign q_in = {f_now, f_coord, f_cmd};

    // queue between front and back
    ttgt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (q_in),
        .pop_valid  (b_pop_valid),
        .pop_ready  (b_pop_ready),
        .pop_data   (q_out)
    );

    // back: gestures and results
    ttgt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (b_pop_valid),
        .pop_ready       (b_pop_ready),
        .pop_command     (q_out[1:0]),
        .pop_coord       (q_out[COORD_BITS+1:2]),
        .pop_now_seconds (q_out[QW-1:COORD_BITS+2]),
        .jump_limit      (jump_limit_reg),
        .glide_start     (glide_start_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_action      (m_tuser),
        .out_move_dx     (out_dx),
        .out_move_dy     (out_dy),
        .out_last        (m_tlast)
    );

    assign m_tdata = {4'd0, out_dy, out_dx};

endmodule

FILE: sv/ttgt_queue.sv
// Small flip-flop FIFO that decouples the front (scaling) from the back (gesture logic).
// Depends on nothing; depth must be a power of two.
module ttgt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

FILE: sv/ttgt_front.sv
// Front end: accepts input words, scales X/Y samples with a bit-serial divider.
// Depends on ttgt_pkg; feeds ttgt_queue.
module ttgt_front #(
    parameter int COORD_BITS = ttgt_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_command,
    input  logic [ttgt_pkg::RAW_BITS-1:0]  in_raw_value,
    input  logic [ttgt_pkg::TIME_BITS-1:0] in_now_seconds,
    input  logic [ttgt_pkg::TOP_BITS-1:0]  x_axis_top,
    input  logic [ttgt_pkg::TOP_BITS-1:0]  y_axis_top,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [1:0]                     push_command,
    output logic [COORD_BITS-1:0]          push_coord,
    output logic [ttgt_pkg::TIME_BITS-1:0] push_now_seconds
);
    import ttgt_pkg::*;

    localparam int WIDE = (COORD_BITS > QUOT_BITS) ? COORD_BITS : QUOT_BITS;
    localparam logic [WIDE-1:0] CMAX = WIDE'((64'd1 << COORD_BITS) - 64'd1);
    localparam int CNT_BITS = $clog2(QUOT_BITS);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t           state_reg, state_next;
    logic [1:0]             cmd_reg;
    logic [RAW_BITS-1:0]    raw_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [DIVR_BITS-1:0]   rem_reg;
    logic [QUOT_BITS-1:0]   quot_reg;
    logic [DIVR_BITS-1:0]   divr_reg;
    logic [CNT_BITS-1:0]    cnt_reg;

    logic signed [RAW_BITS:0] num_s;
    logic [DIVR_BITS-1:0]     num_u;
    logic [PROD_BITS-1:0]     prod;
    logic [DIVR_BITS:0]       trial;
    logic                     trial_ge;
    logic [WIDE-1:0]          quot_wide;

    // offset the raw reading and scale by 255 as (n << 8) - n
    always_comb begin
        num_s = {raw_reg[RAW_BITS-1], raw_reg} + $signed({1'b0, RAW_OFFSET});
        num_u = num_s[DIVR_BITS-1:0];
        if (num_s[RAW_BITS] || num_s == '0) prod = '0;
        else prod = {num_u, 8'd0} - PROD_BITS'(num_u);
    end

    // one restoring division step
    always_comb begin
        trial    = {rem_reg, quot_reg[QUOT_BITS-1]};
        trial_ge = (trial >= {1'b0, divr_reg});
    end

    assign quot_wide = WIDE'(quot_reg);

    assign in_ready         = (state_reg == F_IDLE);
    assign push_valid       = (state_reg == F_PUSH);
    assign push_command     = cmd_reg;
    assign push_now_seconds = now_reg;
    assign push_coord       = (quot_wide > CMAX) ? COORD_BITS'(CMAX)
                                                 : COORD_BITS'(quot_wide);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    if (in_command == CMD_X_SAMPLE || in_command == CMD_Y_SAMPLE)
                        state_next = F_MUL;
                    else
                        state_next = F_PUSH;
                end
            end
            F_MUL:  state_next = F_DIV;
            F_DIV: begin
                if (cnt_reg == CNT_BITS'(QUOT_BITS - 1)) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= F_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    cmd_reg  <= in_command;
                    raw_reg  <= in_raw_value;
                    now_reg  <= in_now_seconds;
                    quot_reg <= '0;
                end
            end
            F_MUL: begin
                rem_reg  <= {1'b0, prod[PROD_BITS-1:QUOT_BITS]};
                quot_reg <= prod[QUOT_BITS-1:0];
                divr_reg <= {1'b0, (cmd_reg == CMD_X_SAMPLE) ? x_axis_top : y_axis_top}
                            + RAW_OFFSET;
                cnt_reg  <= '0;
            end
            F_DIV: begin
                rem_reg  <= trial_ge ? DIVR_BITS'(trial - {1'b0, divr_reg})
                                     : trial[DIVR_BITS-1:0];
                quot_reg <= {quot_reg[QUOT_BITS-2:0], trial_ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV) |-> (cnt_reg <= CNT_BITS'(QUOT_BITS - 1)))
        else $error("divider ran past its step count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_MUL) |=> (state_reg == F_DIV))
        else $error("scaling did not enter the divider");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV) |-> (rem_reg < divr_reg))
        else $error("partial remainder not below divisor");

endmodule

FILE: sv/ttgt_back.sv
// Back end: tap, glide and jump logic over queued words; owns the result register.
// Depends on ttgt_pkg; fed by ttgt_queue.
module ttgt_back #(
    parameter int COORD_BITS = ttgt_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  logic [1:0]                      pop_command,
    input  logic [COORD_BITS-1:0]           pop_coord,
    input  logic [ttgt_pkg::TIME_BITS-1:0]  pop_now_seconds,
    input  logic [ttgt_pkg::LIM_BITS-1:0]   jump_limit,
    input  logic [ttgt_pkg::LIM_BITS-1:0]   glide_start,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      out_action,
    output logic [ttgt_pkg::DELTA_BITS-1:0] out_move_dx,
    output logic [ttgt_pkg::DELTA_BITS-1:0] out_move_dy,
    output logic                            out_last
);
    import ttgt_pkg::*;

    localparam int SB = COORD_BITS + 1;
    localparam logic signed [SB:0] D_MAX = 31;
    localparam logic signed [SB:0] D_MIN = -32;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_JUDGE = 3'b010,
        ST_MOVE  = 3'b100
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [COORD_BITS-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]  prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic                   gliding_reg, gliding_next;
    logic [LIM_BITS-1:0]    travel_reg, travel_next;
    logic [TIME_BITS-1:0]   tap_start_reg, tap_start_next;
    logic                   ignore_left_reg, ignore_left_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic                   click_pend_reg, click_pend_next;
    logic [1:0]             click_act_reg, click_act_next;
    logic [DELTA_BITS-1:0]  pend_dx_reg, pend_dx_next, pend_dy_reg, pend_dy_next;
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_action_reg, m_action_next;
    logic [DELTA_BITS-1:0]  m_dx_reg, m_dx_next, m_dy_reg, m_dy_next;
    logic                   m_last_reg, m_last_next;

    logic signed [SB-1:0]   dx_s, dy_s;
    logic [COORD_BITS-1:0]  adx, ady;
    logic [COORD_BITS:0]    step_sum;
    logic                   is_jump;
    logic [LIM_BITS:0]      travel_add;
    logic [LIM_BITS-1:0]    travel_sat;
    logic                   glide_new;
    logic                   move_gen;
    logic [DELTA_BITS-1:0]  enc_dx, enc_dy;
    logic                   out_free;

    // doubled step, saturated to six signed bits
    function automatic logic [DELTA_BITS-1:0] enc_delta(input logic signed [SB-1:0] d);
        logic signed [SB:0] d2;
        d2 = {d, 1'b0};
        if (d2 > D_MAX)      enc_delta = D_MAX[DELTA_BITS-1:0];
        else if (d2 < D_MIN) enc_delta = D_MIN[DELTA_BITS-1:0];
        else                 enc_delta = d2[DELTA_BITS-1:0];
    endfunction

    // step judgement from the registered coordinates
    always_comb begin
        dx_s       = $signed({1'b0, cur_x_reg}) - $signed({1'b0, prev_x_reg});
        dy_s       = $signed({1'b0, cur_y_reg}) - $signed({1'b0, prev_y_reg});
        adx        = dx_s[SB-1] ? COORD_BITS'(-dx_s) : COORD_BITS'(dx_s);
        ady        = dy_s[SB-1] ? COORD_BITS'(-dy_s) : COORD_BITS'(dy_s);
        step_sum   = {1'b0, adx} + {1'b0, ady};
        is_jump    = step_sum > (COORD_BITS + 1)'(jump_limit);
        travel_add = {1'b0, travel_reg} + {1'b0, step_sum[LIM_BITS-1:0]};
        travel_sat = travel_add[LIM_BITS] ? '1 : travel_add[LIM_BITS-1:0];
        glide_new  = gliding_reg | (travel_sat > glide_start);
        move_gen   = !is_jump && glide_new;
        enc_dx     = enc_delta(dx_s);
        enc_dy     = enc_delta(dy_s);
    end

    assign out_free  = !m_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE);

    assign out_valid   = m_valid_reg;
    assign out_action  = m_action_reg;
    assign out_move_dx = m_dx_reg;
    assign out_move_dy = m_dy_reg;
    assign out_last    = m_last_reg;

    // next state
    always_comb begin
        state_next       = state_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        gliding_next     = gliding_reg;
        travel_next      = travel_reg;
        tap_start_next   = tap_start_reg;
        ignore_left_next = ignore_left_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        click_pend_next  = click_pend_reg;
        click_act_next   = click_act_reg;
        pend_dx_next     = pend_dx_reg;
        pend_dy_next     = pend_dy_reg;
        m_valid_next     = m_valid_reg && !out_ready;
        m_action_next    = m_action_reg;
        m_dx_next        = m_dx_reg;
        m_dy_next        = m_dy_reg;
        m_last_next      = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    cmd_next        = pop_command;
                    now_next        = pop_now_seconds;
                    click_pend_next = 1'b0;
                    case (pop_command)
                        CMD_X_SAMPLE: begin
                            prev_x_next = cur_x_reg;
                            cur_x_next  = pop_coord;
                        end
                        CMD_Y_SAMPLE: begin
                            prev_y_next = cur_y_reg;
                            cur_y_next  = pop_coord;
                        end
                        CMD_FINGER_UP: begin
                            if (gliding_reg) begin
                                ignore_left_next = 1'b1;
                            end else if (pop_now_seconds != tap_start_reg) begin
                                click_pend_next  = 1'b1;
                                click_act_next   = ACT_RIGHT;
                                ignore_left_next = 1'b1;
                            end else if (ignore_left_reg) begin
                                ignore_left_next = 1'b0;
                            end else begin
                                click_pend_next  = 1'b1;
                                click_act_next   = ACT_LEFT;
                                ignore_left_next = 1'b1;
                            end
                            gliding_next = 1'b0;
                        end
                        default: ;
                    endcase
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (out_free) begin
                    if (is_jump) begin
                        if (!gliding_reg) begin
                            travel_next = '0;
                            if (cur_x_reg != '0 && cur_y_reg != '0)
                                tap_start_next = now_reg;
                        end
                    end else begin
                        travel_next  = travel_sat;
                        gliding_next = glide_new;
                    end
                    state_next = ST_IDLE;
                    if (click_pend_reg) begin
                        m_valid_next  = 1'b1;
                        m_action_next = click_act_reg;
                        m_dx_next     = '0;
                        m_dy_next     = '0;
                        m_last_next   = !move_gen;
                        if (move_gen) begin
                            pend_dx_next = enc_dx;
                            pend_dy_next = enc_dy;
                            state_next   = ST_MOVE;
                        end
                    end else if (move_gen) begin
                        m_valid_next  = 1'b1;
                        m_action_next = ACT_MOVE;
                        m_dx_next     = enc_dx;
                        m_dy_next     = enc_dy;
                        m_last_next   = 1'b1;
                    end
                end
            end
            ST_MOVE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_MOVE;
                    m_dx_next     = pend_dx_reg;
                    m_dy_next     = pend_dy_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and gesture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            gliding_reg     <= 1'b0;
            travel_reg      <= '0;
            tap_start_reg   <= '0;
            ignore_left_reg <= 1'b1;
            click_pend_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            gliding_reg     <= gliding_next;
            travel_reg      <= travel_next;
            tap_start_reg   <= tap_start_next;
            ignore_left_reg <= ignore_left_next;
            click_pend_reg  <= click_pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        now_reg       <= now_next;
        click_act_reg <= click_act_next;
        pend_dx_reg   <= pend_dx_next;
        pend_dy_reg   <= pend_dy_next;
        m_action_reg  <= m_action_next;
        m_dx_reg      <= m_dx_next;
        m_dy_reg      <= m_dy_next;
        m_last_reg    <= m_last_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |-> m_valid_reg)
        else $error("pending move without a click ahead of it");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> (state_reg == ST_JUDGE))
        else $error("popped word not judged next");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_JUDGE && cmd_reg == CMD_FINGER_UP) |-> !gliding_reg)
        else $error("glide survived finger-up");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (travel_reg != $past(travel_reg)) |->
            (travel_reg == '0 || travel_reg > $past(travel_reg)))
        else $error("travel fell without a restart");

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for touchpad_tap_and_glide_translator: stream words in, moves/clicks out.
// Predicts every accepted word in-line, checks results in order; register port written when idle.
// Depends on ttgt_pkg and the block's RTL.
module tb_top;
    import ttgt_pkg::*;

    localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
    localparam int RANDOM_WORDS = 160;  // per register setting, six settings
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] raw;
        logic [31:0]        secs;
    } pad_word_t;

    typedef struct {
        logic [1:0] act;
        logic [5:0] dx;
        logic [5:0] dy;
        logic       last;
    } ptr_event_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // raw_value [15:0], now_seconds [47:16]
    logic [1:0]  s_tuser  = '0;   // command [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // move_dx [5:0], move_dy [11:6], zero [15:12]
    logic [1:0]  m_tuser;         // action [1:0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    touchpad_tap_and_glide_translator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock, period 8
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Hard stop
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // Bench-side copy of the registers
    logic [TOP_BITS-1:0] cfg_x_top       = X_TOP_RST;
    logic [TOP_BITS-1:0] cfg_y_top       = Y_TOP_RST;
    logic [LIM_BITS-1:0] cfg_jump_limit  = JUMP_LIMIT_RST;
    logic [LIM_BITS-1:0] cfg_glide_start = GLIDE_START_RST;

    // Bench-side copy of the gesture state
    logic [COORD_BITS_DEF-1:0] pos_x = '0, pos_y = '0, last_x = '0, last_y = '0;
    logic                      glide_on    = 1'b0;
    logic [7:0]                travel_sum  = '0;
    logic [31:0]               tap_second  = '0;
    logic                      skip_left   = 1'b1;

    pad_word_t  pad_words_pending[$];
    ptr_event_t pointer_events_due[$];
    int         words_queued = 0;
    int         words_taken  = 0;
    int         err_count    = 0;

    // Stimulus walk state
    int          walk_x = 0, walk_y = 0;
    logic [31:0] wall_clock = '0;

    task automatic flag_mismatch(input string msg);
        if (err_count < 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [COORD_BITS_DEF-1:0] scale_raw(input logic signed [15:0] raw,
                                                             input logic [TOP_BITS-1:0] top);
        int num;
        int c;
        num = int'(raw) + 32767;
        if (num <= 0)
            return '0;
        c = (num * 255) / (int'(top) + 32767);
        if (c > COORD_MAX)
            c = COORD_MAX;
        return c[COORD_BITS_DEF-1:0];
    endfunction

    // Doubled step, saturated to the 6-bit signed range
    function automatic logic [5:0] doubled_step(input int d);
        int v;
        v = 2 * d;
        if (v > 31)
            v = 31;
        if (v < -32)
            v = -32;
        return v[5:0];
    endfunction

    function automatic int coord_gap(input logic [COORD_BITS_DEF-1:0] a,
                                     input logic [COORD_BITS_DEF-1:0] b);
        return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Predict the results of one accepted word and update the state copy
    task automatic translate_word(input pad_word_t w);
        ptr_event_t evs[2];
        int         n;
        int         step;
        int         sum;
        n = 0;
        case (w.cmd)
            CMD_X_SAMPLE: begin
                last_x = pos_x;
                pos_x  = scale_raw(w.raw, cfg_x_top);
            end
            CMD_Y_SAMPLE: begin
                last_y = pos_y;
                pos_y  = scale_raw(w.raw, cfg_y_top);
            end
            CMD_FINGER_UP: begin
                if (!glide_on) begin
                    if (w.secs != tap_second) begin
                        evs[n] = '{ACT_RIGHT, 6'd0, 6'd0, 1'b0};
                        n++;
                        skip_left = 1'b1;
                    end else if (skip_left) begin
                        skip_left = 1'b0;
                    end else begin
                        evs[n] = '{ACT_LEFT, 6'd0, 6'd0, 1'b0};
                        n++;
                        skip_left = 1'b1;
                    end
                end else begin
                    skip_left = 1'b1;
                end
                glide_on = 1'b0;
            end
            default: ;
        endcase

        // step judgement runs after every word
        step = coord_gap(pos_x, last_x) + coord_gap(pos_y, last_y);
        if (step > int'(cfg_jump_limit)) begin
            if (!glide_on) begin
                travel_sum = '0;
                if (pos_x != 0 && pos_y != 0)
                    tap_second = w.secs;
            end
        end else begin
            sum = int'(travel_sum) + step;
            travel_sum = (sum > 255) ? 8'd255 : sum[7:0];
            if (travel_sum > cfg_glide_start)
                glide_on = 1'b1;
            if (glide_on) begin
                evs[n] = '{ACT_MOVE,
                           doubled_step(int'(pos_x) - int'(last_x)),
                           doubled_step(int'(pos_y) - int'(last_y)), 1'b0};
                n++;
            end
        end

        if (n > 0)
            evs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pointer_events_due.push_back(evs[k]);
    endtask

    task automatic queue_word(input logic [1:0] cmd, input logic [15:0] raw,
                              input logic [31:0] secs);
        pad_word_t w;
        w.cmd  = cmd;
        w.raw  = raw;
        w.secs = secs;
        pad_words_pending.push_back(w);
        words_queued++;
    endtask

    function automatic int clamp_raw(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Mostly finger walks with small steps, some jumps, taps and noise
    task automatic queue_random_word();
        int          r;
        int          ux;
        int          uy;
        logic [31:0] secs;
        ux = (int'(cfg_x_top) + 32767) / 255 + 1;
        uy = (int'(cfg_y_top) + 32767) / 255 + 1;
        if ($urandom_range(15) == 0)
            wall_clock = wall_clock + 32'd1;
        secs = wall_clock;
        r = $urandom_range(99);
        if (r < 30) begin
            walk_x = clamp_raw(walk_x + int'($urandom_range(6 * ux)) - 3 * ux);
            queue_word(CMD_X_SAMPLE, walk_x[15:0], secs);
        end else if (r < 60) begin
            walk_y = clamp_raw(walk_y + int'($urandom_range(6 * uy)) - 3 * uy);
            queue_word(CMD_Y_SAMPLE, walk_y[15:0], secs);
        end else if (r < 66) begin
            walk_x = clamp_raw(int'($urandom_range(65535)) - 32768);
            queue_word(CMD_X_SAMPLE, walk_x[15:0], secs);
        end else if (r < 72) begin
            walk_y = clamp_raw(int'($urandom_range(65535)) - 32768);
            queue_word(CMD_Y_SAMPLE, walk_y[15:0], secs);
        end else if (r < 86) begin
            if ($urandom_range(3) == 0)
                secs = secs + 32'd1;
            queue_word(CMD_FINGER_UP, 16'($urandom_range(65535)), secs);
        end else if (r < 93) begin
            queue_word(CMD_OTHER, 16'($urandom_range(65535)), secs);
        end else begin
            queue_word(2'($urandom_range(3)), 16'($urandom_range(65535)), $urandom);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_X_TOP:       cfg_x_top       = val[TOP_BITS-1:0];
            REG_Y_TOP:       cfg_y_top       = val[TOP_BITS-1:0];
            REG_JUMP_LIMIT:  cfg_jump_limit  = val[LIM_BITS-1:0];
            REG_GLIDE_START: cfg_glide_start = val[LIM_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int ph);
        case (ph)
            1: begin
                write_reg(REG_X_TOP, 0);
                write_reg(REG_Y_TOP, 0);
                write_reg(REG_JUMP_LIMIT, 0);
                write_reg(REG_GLIDE_START, 0);
            end
            2: begin
                write_reg(REG_X_TOP, 32767);
                write_reg(REG_Y_TOP, 32767);
                write_reg(REG_JUMP_LIMIT, 255);
                write_reg(REG_GLIDE_START, 255);
            end
            3: begin
                // jump limit above 15 lets the doubled steps saturate
                write_reg(REG_X_TOP, 20000);
                write_reg(REG_Y_TOP, 8000);
                write_reg(REG_JUMP_LIMIT, 40);
                write_reg(REG_GLIDE_START, 3);
            end
            4: begin
                write_reg(REG_X_TOP, $urandom_range(32767));
                write_reg(REG_Y_TOP, $urandom_range(32767));
                write_reg(REG_JUMP_LIMIT, $urandom_range(255));
                write_reg(REG_GLIDE_START, $urandom_range(255));
            end
            default: begin
                write_reg(REG_X_TOP, 1);
                write_reg(REG_Y_TOP, 32767);
                write_reg(REG_JUMP_LIMIT, 255);
                write_reg(REG_GLIDE_START, 0);
            end
        endcase
    endtask

    // Wait until every word is taken and every result is in, then let the block settle
    task automatic drain();
        while (words_taken != words_queued || pointer_events_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: bursts of random length with random gaps
    int        burst_left = 1;
    int        gap_left   = 0;
    pad_word_t word_on_bus;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                translate_word(word_on_bus);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pad_words_pending.size() != 0) begin
                    word_on_bus = pad_words_pending.pop_front();
                    s_tuser  <= word_on_bus.cmd;
                    s_tdata  <= {word_on_bus.secs, word_on_bus.raw};
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern changes mode after a random stretch
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(3);
                stall_left = $urandom_range(8, 64);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(1));
                2:       m_tready <= ($urandom_range(3) == 0);
                default: m_tready <= (stall_left % 5) != 0;
            endcase
        end
    end

    // Result checker, in order, field by field
    always @(posedge aclk) begin : result_check
        ptr_event_t ev;
        if (aresetn && m_tvalid && m_tready) begin
            if (pointer_events_due.size() == 0) begin
                flag_mismatch($sformatf("result word with nothing expected (action %0d)",
                                        m_tuser));
            end else begin
                ev = pointer_events_due.pop_front();
                if (m_tuser !== ev.act)
                    flag_mismatch($sformatf("action %0d, expected %0d", m_tuser, ev.act));
                if (m_tdata[5:0] !== ev.dx)
                    flag_mismatch($sformatf("move_dx %0d, expected %0d",
                                            $signed(m_tdata[5:0]), $signed(ev.dx)));
                if (m_tdata[11:6] !== ev.dy)
                    flag_mismatch($sformatf("move_dy %0d, expected %0d",
                                            $signed(m_tdata[11:6]), $signed(ev.dy)));
                if (m_tlast !== ev.last)
                    flag_mismatch($sformatf("last %0b, expected %0b", m_tlast, ev.last));
            end
        end
    end

    // Main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, register defaults
        queue_word(CMD_OTHER,     16'h0000, 32'h0000_0000);
        queue_word(CMD_X_SAMPLE,  16'h8000, 32'h0000_0000);  // clamps to zero
        queue_word(CMD_Y_SAMPLE,  16'h7FFF, 32'h0000_0000);  // jump, x still zero
        queue_word(CMD_X_SAMPLE,  16'h7FFF, 32'hFFFF_FFFF);  // jump, tap timer starts
        queue_word(CMD_FINGER_UP, 16'h0000, 32'hFFFF_FFFF);  // first quick tap swallowed
        queue_word(CMD_FINGER_UP, 16'hFFFF, 32'hFFFF_FFFF);  // second quick tap: left click
        queue_word(CMD_FINGER_UP, 16'h0000, 32'h0000_0000);  // second elapsed: right click
        queue_word(CMD_X_SAMPLE,  16'h7FFF, 32'h0000_0000);
        queue_word(CMD_Y_SAMPLE,  16'h7FFF, 32'h0000_0000);  // zero step
        queue_word(CMD_X_SAMPLE,  16'd32100, 32'h0000_0000); // small steps build travel
        queue_word(CMD_X_SAMPLE,  16'd31500, 32'h0000_0000);
        queue_word(CMD_X_SAMPLE,  16'd30900, 32'h0000_0000);
        queue_word(CMD_X_SAMPLE,  16'd30300, 32'h0000_0000);
        queue_word(CMD_X_SAMPLE,  16'd29700, 32'h0000_0000);
        queue_word(CMD_OTHER,     16'h5555, 32'h0000_0000);  // same step judged again
        queue_word(CMD_FINGER_UP, 16'hAAAA, 32'h0000_0000);  // finger up while gliding
        queue_word(CMD_FINGER_UP, 16'h0000, 32'h0000_0001);
        queue_word(CMD_Y_SAMPLE,  16'h8001, 32'h0000_0001);  // scales to exactly zero
        queue_word(CMD_Y_SAMPLE,  16'h0000, 32'h0000_0001);
        queue_word(CMD_X_SAMPLE,  16'h5555, 32'h5555_AAAA);
        queue_word(CMD_X_SAMPLE,  16'hAAAA, 32'hAAAA_5555);
        queue_word(CMD_FINGER_UP, 16'h5555, 32'h5555_AAAA);
        queue_word(CMD_OTHER,     16'hFFFF, 32'hAAAA_5555);
        drain();

        // random part over several register settings
        wall_clock = $urandom;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0)
                apply_setting(ph);
            for (int k = 0; k < RANDOM_WORDS; k++)
                queue_random_word();
            drain();
        end

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: touchpad_tap_and_glide_translator.f
sv/ttgt_pkg.sv
sv/ttgt_queue.sv
sv/ttgt_front.sv
sv/ttgt_back.sv
sv/touchpad_tap_and_glide_translator.sv
sim/tb_top.sv
